>>> hw/rtl/il4cr_pkg.sv
`default_nettype none

package il4cr_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_REWRITTEN = 2'd0,
        ST_UNCHANGED = 2'd1,
        ST_REJECTED  = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    // IPv4 header constants.
    localparam logic [7:0]  VER_IHL     = 8'h45;
    localparam logic [7:0]  FRAG_MASK   = 8'h3f;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [15:0] IP_HDR_LEN  = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN = 16'd8;
    localparam logic [15:0] TCP_HDR_MIN = 16'd20;
    localparam logic [15:0] CSUM_ONES   = 16'hffff;

    // Byte offsets of the checksum field.
    localparam logic [5:0] POS_TCP  = 6'd36;
    localparam logic [5:0] POS_UDP  = 6'd26;
    localparam logic [5:0] POS_NONE = 6'd0;

    // Depth of the record queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // One classified packet, handed from the front to the back.
    typedef struct packed {
        status_t     status;
        logic [5:0]  pos;
        logic [15:0] len;
        logic [16:0] sum;
    } pkt_rec_t;

endpackage

`default_nettype wire

>>> hw/rtl/il4cr_front.sv
`default_nettype none

module il4cr_front #(
    parameter int MAX_LEN = 1535
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               packet_valid,
    output logic                    packet_stall,
    input  wire logic [7:0]         packet_byte,
    input  wire logic               last_byte,
    input  wire logic               queue_full,
    output logic                    push,
    output il4cr_pkg::pkt_rec_t     push_rec
);

    localparam int CNT_W = $clog2(MAX_LEN + 2);
    localparam int IDX_W = (CNT_W < 6) ? 6 : CNT_W;
    localparam int CMP_W = 17;

    logic [IDX_W-1:0] count_reg, count_next;
    logic [16:0]      sum_reg, sum_next;
    logic [15:0]      tot_len_reg, tot_len_next;
    logic [7:0]       proto_reg, proto_next;
    logic [15:0]      seg_len_reg, seg_len_next;
    logic             fault_reg, fault_next;
    logic [7:0]       held_reg, held_next;
    logic             udp_abs_reg, udp_abs_next;

    logic             accept;
    logic [CMP_W-1:0] idx;
    logic [CMP_W-1:0] n;
    logic [15:0]      byte_val;
    logic [17:0]      sum_wide;
    logic             covered;
    logic [15:0]      l4_len;
    logic [5:0]       doff;
    il4cr_pkg::pkt_rec_t rec;

    assign packet_stall = queue_full;
    assign accept       = packet_valid && !queue_full;
    assign push         = accept && last_byte;
    assign push_rec     = rec;

    // Header parsing and checksum accumulation for the current byte.
    always_comb
    begin
        idx          = CMP_W'(count_reg);
        tot_len_next = tot_len_reg;
        proto_next   = proto_reg;
        seg_len_next = seg_len_reg;
        fault_next   = fault_reg;
        held_next    = held_reg;
        udp_abs_next = udp_abs_reg;

        if (count_reg == IDX_W'(0) && packet_byte != il4cr_pkg::VER_IHL)
        begin
            fault_next = 1'b1;
        end
        if (count_reg == IDX_W'(2))
        begin
            tot_len_next = {packet_byte, 8'h00};
        end
        if (count_reg == IDX_W'(3))
        begin
            tot_len_next = tot_len_reg | {8'h00, packet_byte};
            seg_len_next = (tot_len_next >= il4cr_pkg::IP_HDR_LEN) ?
                           tot_len_next - il4cr_pkg::IP_HDR_LEN : 16'd0;
        end
        if (count_reg == IDX_W'(6) && (packet_byte & il4cr_pkg::FRAG_MASK) != 8'h00)
        begin
            fault_next = 1'b1;
        end
        if (count_reg == IDX_W'(7) && packet_byte != 8'h00)
        begin
            fault_next = 1'b1;
        end
        if (count_reg == IDX_W'(9))
        begin
            proto_next = packet_byte;
        end
        if (count_reg == IDX_W'(24))
        begin
            held_next = packet_byte;
        end
        if (count_reg == IDX_W'(25) && proto_reg == il4cr_pkg::PROTO_UDP)
        begin
            seg_len_next = {held_reg, packet_byte};
        end
        if (count_reg == IDX_W'(26))
        begin
            udp_abs_next = (packet_byte == 8'h00);
        end
        if (count_reg == IDX_W'(27))
        begin
            udp_abs_next = udp_abs_reg && (packet_byte == 8'h00);
        end
        if (count_reg == IDX_W'(32) && proto_reg == il4cr_pkg::PROTO_TCP)
        begin
            held_next = packet_byte;
        end

        // Pseudo-header addresses, then the segment up to its length,
        // leaving out the checksum field itself.
        covered = 1'b0;
        if (idx >= CMP_W'(12) && idx < CMP_W'(20))
        begin
            covered = 1'b1;
        end
        if (idx >= CMP_W'(20) && idx < ({1'b0, seg_len_next} + CMP_W'(20))
            && idx < {1'b0, tot_len_next})
        begin
            covered = 1'b1;
        end
        if (proto_next == il4cr_pkg::PROTO_TCP
            && (count_reg == IDX_W'(36) || count_reg == IDX_W'(37)))
        begin
            covered = 1'b0;
        end
        if (proto_next == il4cr_pkg::PROTO_UDP
            && (count_reg == IDX_W'(26) || count_reg == IDX_W'(27)))
        begin
            covered = 1'b0;
        end

        byte_val = count_reg[0] ? {8'h00, packet_byte} : {packet_byte, 8'h00};
        sum_wide = {1'b0, sum_reg} + {2'b00, byte_val};
        sum_next = covered ? ({1'b0, sum_wide[15:0]} + {15'd0, sum_wide[17:16]})
                           : sum_reg;

        count_next = (count_reg == IDX_W'(MAX_LEN + 1)) ? count_reg
                                                         : count_reg + IDX_W'(1);
    end

    // Classification of the packet, valid when the marked byte is taken.
    always_comb
    begin
        n      = CMP_W'(count_next);
        l4_len = (tot_len_next >= il4cr_pkg::IP_HDR_LEN) ?
                 tot_len_next - il4cr_pkg::IP_HDR_LEN : 16'd0;
        doff   = {held_next[7:4], 2'b00};

        rec.status = il4cr_pkg::ST_UNCHANGED;
        rec.pos    = il4cr_pkg::POS_NONE;
        rec.len    = l4_len;
        rec.sum    = sum_next;

        if (n < CMP_W'(20))
        begin
            rec.status = il4cr_pkg::ST_TRUNCATED;
        end
        else if (fault_next || tot_len_next < il4cr_pkg::IP_HDR_LEN
                 || {1'b0, tot_len_next} > CMP_W'(MAX_LEN))
        begin
            rec.status = il4cr_pkg::ST_REJECTED;
        end
        else if (n < {1'b0, tot_len_next})
        begin
            rec.status = il4cr_pkg::ST_TRUNCATED;
        end
        else if (proto_next == il4cr_pkg::PROTO_TCP)
        begin
            if (l4_len < il4cr_pkg::TCP_HDR_MIN || {10'd0, doff} < il4cr_pkg::TCP_HDR_MIN
                || {10'd0, doff} > l4_len)
            begin
                rec.status = il4cr_pkg::ST_REJECTED;
            end
            else
            begin
                rec.status = il4cr_pkg::ST_REWRITTEN;
                rec.pos    = il4cr_pkg::POS_TCP;
            end
        end
        else if (proto_next == il4cr_pkg::PROTO_UDP)
        begin
            rec.len = seg_len_next;
            if (l4_len < il4cr_pkg::UDP_HDR_LEN || seg_len_next < il4cr_pkg::UDP_HDR_LEN
                || seg_len_next > l4_len)
            begin
                rec.status = il4cr_pkg::ST_REJECTED;
            end
            else if (!udp_abs_next)
            begin
                rec.status = il4cr_pkg::ST_REWRITTEN;
                rec.pos    = il4cr_pkg::POS_UDP;
            end
        end
    end

    // Per-packet state, cleared after each marked byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sum_reg     <= '0;
            tot_len_reg <= '0;
            proto_reg   <= '0;
            seg_len_reg <= '0;
            fault_reg   <= 1'b0;
            held_reg    <= '0;
            udp_abs_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                count_reg   <= '0;
                sum_reg     <= '0;
                tot_len_reg <= '0;
                proto_reg   <= '0;
                seg_len_reg <= '0;
                fault_reg   <= 1'b0;
                held_reg    <= '0;
                udp_abs_reg <= 1'b0;
            end
            else
            begin
                count_reg   <= count_next;
                sum_reg     <= sum_next;
                tot_len_reg <= tot_len_next;
                proto_reg   <= proto_next;
                seg_len_reg <= seg_len_next;
                fault_reg   <= fault_next;
                held_reg    <= held_next;
                udp_abs_reg <= udp_abs_next;
            end
        end
    end

    // The byte counter never runs past its saturation point.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= IDX_W'(MAX_LEN + 1))
        else $error("byte counter beyond saturation");

    // The folded running sum never exceeds one end-around carry.
    assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= 17'h10000)
        else $error("running sum not folded");

    // A marked byte leaves the front cleared for the next packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (count_reg == '0 && sum_reg == '0))
        else $error("state not cleared after packet end");

endmodule

`default_nettype wire

>>> hw/rtl/il4cr_queue.sv
`default_nettype none

module il4cr_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire il4cr_pkg::pkt_rec_t  push_rec,
    input  wire logic                 pop,
    output il4cr_pkg::pkt_rec_t       pop_rec,
    output logic                      full,
    output logic                      empty
);

    localparam int CNT_W = il4cr_pkg::QPTR_W + 1;

    il4cr_pkg::pkt_rec_t mem [il4cr_pkg::QUEUE_DEPTH];

    logic [il4cr_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [il4cr_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]             fill_reg, fill_next;
    logic                         do_push;
    logic                         do_pop;

    assign full    = (fill_reg == CNT_W'(il4cr_pkg::QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = mem[rd_ptr_reg];

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + il4cr_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + il4cr_pkg::QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    // The fill level never exceeds the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(il4cr_pkg::QUEUE_DEPTH))
        else $error("queue overfilled");

    // Pointers stay consistent with the fill level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0 || fill_reg == CNT_W'(il4cr_pkg::QUEUE_DEPTH))
        |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill level");

    // A push into a full queue is never requested.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

endmodule

`default_nettype wire

>>> hw/rtl/il4cr_back.sv
`default_nettype none

module il4cr_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 queue_empty,
    input  wire il4cr_pkg::pkt_rec_t  queue_rec,
    output logic                      pop,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic [1:0]                status,
    output logic [15:0]               new_checksum,
    output logic [5:0]                checksum_position
);

    // Stage one: running sum plus protocol and length.
    logic                s1_valid_reg;
    il4cr_pkg::status_t  s1_status_reg;
    logic [5:0]          s1_pos_reg;
    logic [17:0]         s1_total_reg;

    // Output register.
    logic                out_valid_reg;
    il4cr_pkg::status_t  out_status_reg;
    logic [15:0]         out_csum_reg;
    logic [5:0]          out_pos_reg;

    logic                advance;
    logic                s1_load;
    logic [7:0]          proto;
    logic [17:0]         total_next;
    logic [16:0]         fold1;
    logic [16:0]         fold2;
    logic [15:0]         csum_inv;
    logic [15:0]         csum_next;

    assign advance = !out_valid_reg || !result_stall;
    assign s1_load = !s1_valid_reg || advance;
    assign pop     = s1_load && !queue_empty;

    // Add the pseudo-header protocol and length to the packet sum.
    always_comb
    begin
        proto = (queue_rec.pos == il4cr_pkg::POS_TCP) ? il4cr_pkg::PROTO_TCP
                                                      : il4cr_pkg::PROTO_UDP;
        total_next = {1'b0, queue_rec.sum} + {10'd0, proto} + {2'b00, queue_rec.len};
    end

    // Fold twice, complement, send zero as all ones; zero if not rewritten.
    always_comb
    begin
        fold1     = {1'b0, s1_total_reg[15:0]} + {15'd0, s1_total_reg[17:16]};
        fold2     = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
        csum_inv  = ~fold2[15:0];
        csum_next = (csum_inv == 16'h0000) ? il4cr_pkg::CSUM_ONES : csum_inv;
        if (s1_status_reg != il4cr_pkg::ST_REWRITTEN)
        begin
            csum_next = 16'h0000;
        end
    end

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= !queue_empty;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload of both stages.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_status_reg <= queue_rec.status;
            s1_pos_reg    <= queue_rec.pos;
            s1_total_reg  <= total_next;
        end
        if (advance && s1_valid_reg)
        begin
            out_status_reg <= s1_status_reg;
            out_csum_reg   <= csum_next;
            out_pos_reg    <= s1_pos_reg;
        end
    end

    assign result_valid      = out_valid_reg;
    assign status            = out_status_reg;
    assign new_checksum      = out_csum_reg;
    assign checksum_position = out_pos_reg;

    // A rewritten item carries a nonzero checksum at a TCP or UDP offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == il4cr_pkg::ST_REWRITTEN)
        |-> (out_csum_reg != 16'h0000
             && (out_pos_reg == il4cr_pkg::POS_TCP || out_pos_reg == il4cr_pkg::POS_UDP)))
        else $error("rewritten item with bad checksum or position");

    // Any other item carries neither checksum nor position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != il4cr_pkg::ST_REWRITTEN)
        |-> (out_csum_reg == 16'h0000 && out_pos_reg == il4cr_pkg::POS_NONE))
        else $error("unrewritten item with checksum or position");

    // An item held in stage one is not lost while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && result_stall) |=> s1_valid_reg)
        else $error("stage one item dropped under stall");

endmodule

`default_nettype wire

>>> hw/rtl/inner_l4_checksum_rewrite_core.sv
// Inner IPv4 TCP/UDP checksum recompute.
// The packet channel (packet_valid, packet_stall, packet_byte, last_byte)
// takes one byte of a decapsulated IPv4 packet per cycle, header first;
// last_byte marks the final byte. The result channel (result_valid,
// result_stall, status, new_checksum, checksum_position) gives one item per
// packet: status 0 with the new checksum and its offset (36 TCP, 26 UDP),
// or status 1 (unchanged), 2 (header rejected) or 3 (truncated).
// Throughput is one byte per cycle while packet_stall is low. After the
// marked byte is taken, its record passes through the queue, then stage
// one, which adds the pseudo-header protocol and length, then the output
// register, which takes the folded and complemented sum.
// A four-entry record queue separates the byte parser from the checksum
// finisher. While the receiver stalls, results wait in the output register,
// stage one and queue; packet_stall rises only once four packets are queued.
// Reset is asynchronous and active low; it empties the queue and both
// stages and clears the parser, so the next byte starts a new packet.
`default_nettype none

module inner_l4_checksum_rewrite_core #(
    parameter int MAX_LEN = 1535
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        packet_valid,
    output logic             packet_stall,
    input  wire logic [7:0]  packet_byte,
    input  wire logic        last_byte,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       status,
    output logic [15:0]      new_checksum,
    output logic [5:0]       checksum_position
);

    logic                 push;
    logic                 pop;
    logic                 queue_full;
    logic                 queue_empty;
    il4cr_pkg::pkt_rec_t  push_rec;
    il4cr_pkg::pkt_rec_t  pop_rec;

    // Byte parser and classifier.
    il4cr_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .packet_valid (packet_valid),
        .packet_stall (packet_stall),
        .packet_byte  (packet_byte),
        .last_byte    (last_byte),
        .queue_full   (queue_full),
        .push         (push),
        .push_rec     (push_rec)
    );

    // Queue of classified packets.
    il4cr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // Checksum finisher and output register.
    il4cr_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .queue_empty       (queue_empty),
        .queue_rec         (pop_rec),
        .pop               (pop),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .status            (status),
        .new_checksum      (new_checksum),
        .checksum_position (checksum_position)
    );

endmodule

`default_nettype wire
